### hdl/htw_pkg.sv
// Shared types, codes and helpers for the Huffman tree-walk decoder.
// No dependencies; htw_if, htw_ctrl and the top level refer to it by scoped names.
`timescale 1ns / 1ps

package htw_pkg;

  localparam int unsigned IDX_W = 9;
  localparam int unsigned SYM_W = 8;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned CFG_W = 32;

  // Request kinds
  localparam logic KIND_NODE = 1'b0;
  localparam logic KIND_BIT  = 1'b1;

  // Configuration register indexes
  localparam logic REG_ROOT_INDEX       = 1'b0;
  localparam logic REG_SYMBOLS_EXPECTED = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_STEP
  } htw_state_t;

  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } htw_emit_t;

  // Reduce a node index modulo the table size by conditional subtraction
  // of shifted copies of the size.
  function automatic logic [IDX_W-1:0] wrap_index(input logic [IDX_W-1:0] v,
                                                  input int unsigned n);
    logic [IDX_W-1:0] r;
    int unsigned m;
    r = v;
    m = 0;
    for (int k = IDX_W - 1; k >= 0; k--) begin
      m = n << k;
      if (32'(r) >= m) begin
        r = r - IDX_W'(m);
      end
    end
    return r;
  endfunction

endpackage

### hdl/htw_if.sv
// Valid/ready channel interfaces for requests in and decoded symbols out.
// Depends on htw_pkg for field widths.
`timescale 1ns / 1ps

interface htw_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [htw_pkg::IDX_W-1:0]   node_index;
  logic                        node_is_leaf;
  logic [htw_pkg::SYM_W-1:0]   node_symbol;
  logic [htw_pkg::IDX_W-1:0]   zero_child;
  logic [htw_pkg::IDX_W-1:0]   one_child;
  logic                        code_bit;

  modport source (
    output valid, kind, node_index, node_is_leaf, node_symbol, zero_child,
           one_child, code_bit,
    input  ready
  );
  modport sink (
    input  valid, kind, node_index, node_is_leaf, node_symbol, zero_child,
           one_child, code_bit,
    output ready
  );
endinterface

interface htw_out_if;
  logic                      valid;
  logic                      ready;
  logic [htw_pkg::SYM_W-1:0] symbol;
  logic                      last;

  modport source (output valid, symbol, last, input ready);
  modport sink (input valid, symbol, last, output ready);
endinterface

### hdl/htw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds while the read enable is low. No dependencies.
`timescale 1ns / 1ps

module htw_ram #(
  parameter int unsigned WIDTH = 27,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/htw_ctrl.sv
// Tree-walk sequencer: node writes, root fetch, up to one table read per bit.
// Depends on htw_pkg and htw_if; drives the node table RAM ports.
`timescale 1ns / 1ps

module htw_ctrl #(
  parameter int unsigned NODE_COUNT = 512
) (
  input  logic                           clk,
  input  logic                           rst,
  htw_in_if.sink                         item,
  input  logic [$clog2(NODE_COUNT)-1:0]  root_addr,
  input  logic                           root_dirty,
  input  logic [htw_pkg::CNT_W-1:0]      symbols_expected,
  input  logic                           slot_free,
  output htw_pkg::htw_emit_t             emit,
  output logic                           wr_en,
  output logic [$clog2(NODE_COUNT)-1:0]  wr_addr,
  output logic [2*$clog2(NODE_COUNT)+htw_pkg::SYM_W:0] wr_data,
  output logic                           rd_en,
  output logic [$clog2(NODE_COUNT)-1:0]  rd_addr,
  input  logic [2*$clog2(NODE_COUNT)+htw_pkg::SYM_W:0] rd_data
);

  localparam int unsigned ADDR_W  = $clog2(NODE_COUNT);
  localparam int unsigned ENTRY_W = 2 * ADDR_W + htw_pkg::SYM_W + 1;
  localparam int unsigned LEAF_B  = ENTRY_W - 1;
  localparam int unsigned SYM_HI  = ENTRY_W - 2;
  localparam int unsigned ZERO_HI = 2 * ADDR_W - 1;
  localparam int unsigned ONE_HI  = ADDR_W - 1;

  htw_pkg::htw_state_t state, state_next;

  logic [ENTRY_W-1:0]        root_entry;
  logic [ENTRY_W-1:0]        cur_entry;
  logic                      root_ok, root_ok_next;
  logic                      at_root, at_root_next;
  logic [htw_pkg::CNT_W-1:0] count, count_next;

  logic [ENTRY_W-1:0]        cur_src;
  logic                      accepted;
  logic                      is_bit;
  logic                      is_node;
  logic                      count_done;
  logic                      step_leaf;
  logic                      walk_go;
  logic                      cur_leaf_emit;
  logic                      step_emit;
  logic [htw_pkg::CNT_W-1:0] count_inc;

  // Current node: fresh read data while a step lands, else cached entries
  assign cur_src = (state == htw_pkg::ST_STEP) ? rd_data
                                               : (at_root ? root_entry : cur_entry);

  assign accepted      = item.valid && item.ready;
  assign is_bit        = accepted && (item.kind == htw_pkg::KIND_BIT);
  assign is_node       = accepted && (item.kind == htw_pkg::KIND_NODE);
  assign count_done    = count >= symbols_expected;
  assign step_leaf     = rd_data[LEAF_B];
  assign walk_go       = is_bit && !count_done && !cur_src[LEAF_B];
  assign cur_leaf_emit = is_bit && !count_done && cur_src[LEAF_B];
  assign step_emit     = (state == htw_pkg::ST_STEP) && step_leaf && slot_free;
  assign count_inc     = count + htw_pkg::CNT_W'(1);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      htw_pkg::ST_IDLE: begin
        // Hold off the fetch while the root register is being rewritten
        if (!root_ok) begin
          if (!root_dirty) begin
            state_next = htw_pkg::ST_FETCH;
          end
        end else if (walk_go) begin
          state_next = htw_pkg::ST_STEP;
        end
      end
      htw_pkg::ST_FETCH: begin
        state_next = htw_pkg::ST_IDLE;
      end
      htw_pkg::ST_STEP: begin
        if (step_leaf) begin
          if (slot_free) begin
            state_next = htw_pkg::ST_IDLE;
          end
        end else if (!walk_go) begin
          state_next = htw_pkg::ST_IDLE;
        end
      end
      default: state_next = htw_pkg::ST_IDLE;
    endcase
  end

  // Outputs and register next values
  always_comb begin
    item.ready   = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = root_addr;
    wr_en        = is_node;
    wr_addr      = ADDR_W'(htw_pkg::wrap_index(item.node_index, NODE_COUNT));
    wr_data      = {item.node_is_leaf, item.node_symbol,
                    ADDR_W'(htw_pkg::wrap_index(item.zero_child, NODE_COUNT)),
                    ADDR_W'(htw_pkg::wrap_index(item.one_child, NODE_COUNT))};
    emit.valid   = 1'b0;
    emit.symbol  = cur_src[SYM_HI -: htw_pkg::SYM_W];
    emit.last    = count_inc == symbols_expected;
    root_ok_next = root_ok;
    at_root_next = at_root;
    count_next   = count;

    unique case (state)
      htw_pkg::ST_IDLE: begin
        item.ready = root_ok && slot_free;
        if (!root_ok) begin
          rd_en = 1'b1;
        end
        if (cur_leaf_emit) begin
          emit.valid = 1'b1;
        end
      end
      htw_pkg::ST_FETCH: begin
        root_ok_next = 1'b1;
      end
      htw_pkg::ST_STEP: begin
        item.ready = !step_leaf;
        if (step_emit) begin
          emit.valid = 1'b1;
        end else if (!step_leaf) begin
          at_root_next = 1'b0;
        end
      end
      default: ;
    endcase

    if (walk_go) begin
      rd_en   = 1'b1;
      rd_addr = item.code_bit ? cur_src[ONE_HI -: ADDR_W] : cur_src[ZERO_HI -: ADDR_W];
    end
    if (emit.valid) begin
      at_root_next = 1'b1;
      count_next   = count_inc;
    end
    if (is_node) begin
      at_root_next = 1'b1;
      count_next   = '0;
      root_ok_next = 1'b0;
    end
    // A root change always forces a refetch, even over a fetch in flight
    if (root_dirty) begin
      root_ok_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= htw_pkg::ST_IDLE;
      root_ok <= 1'b0;
      at_root <= 1'b1;
      count   <= '0;
    end else begin
      state   <= state_next;
      root_ok <= root_ok_next;
      at_root <= at_root_next;
      count   <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == htw_pkg::ST_FETCH) begin
      root_entry <= rd_data;
    end
    if ((state == htw_pkg::ST_STEP) && !step_leaf) begin
      cur_entry <= rd_data;
    end
  end

`ifndef ASSERT_OFF
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("node table read and write in the same cycle");

  a_emit_has_slot: assert property (@(posedge clk) disable iff (rst)
    emit.valid |-> slot_free)
    else $error("symbol emitted while output register is full");

  a_emit_under_count: assert property (@(posedge clk) disable iff (rst)
    emit.valid |-> (count < symbols_expected))
    else $error("symbol emitted past the expected count");

  a_walk_not_leaf: assert property (@(posedge clk) disable iff (rst)
    (state == htw_pkg::ST_IDLE && !at_root) |-> !cur_entry[LEAF_B])
    else $error("walk parked on a leaf node");

  a_fetch_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == htw_pkg::ST_FETCH) |=> (state == htw_pkg::ST_IDLE))
    else $error("root fetch did not complete");
`endif

endmodule

### hdl/huffman_tree_walk_decoder.sv
// Top level of the Huffman tree-walk decoder: configuration registers,
// output register, node table RAM and walk sequencer.
// Depends on htw_pkg, htw_if, htw_ram and htw_ctrl.
`timescale 1ns / 1ps

// Usage
//   item   : request channel. kind 0 writes one tree node (leaf flag, symbol,
//            zero and one child); kind 1 supplies one code bit.
//   result : decoded symbols, last set on the symbol that reaches the
//            expected count.
//   cfg    : write-only registers, index 0 root node, index 1 symbol count.
// Throughput: a code bit that moves to an inner node can be followed at once
//   by the next bit. A bit that lands on a leaf blocks the request channel
//   until its symbol is emitted. The registered read of the node table is the
//   limit: a bit that walks costs one read whose data picks the next address.
//   After a node write the root entry is refetched before requests resume.
// Emit: a symbol found by a table read moves from the RAM read register to the
//   result register when it is free; a leaf root loads as its bit is taken.
// Reset: clears the walk, the count and both registers; the node table keeps
//   its contents and must be loaded before bits are sent. The root entry is
//   fetched after reset by a read in IDLE and then FETCH, with item.ready low.
// Stall: a full output register that is not taken holds item.ready low while
//   the walk is idle or a finished symbol waits for it; nothing is dropped.
module huffman_tree_walk_decoder #(
  parameter int unsigned NODE_COUNT = 512
) (
  input  logic                      clk,
  input  logic                      rst,
  htw_in_if.sink                    item,
  htw_out_if.source                 result,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_index,
  input  logic [htw_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int unsigned ADDR_W  = $clog2(NODE_COUNT);
  localparam int unsigned ENTRY_W = 2 * ADDR_W + htw_pkg::SYM_W + 1;

  logic [ADDR_W-1:0]         root_addr;
  logic [htw_pkg::CNT_W-1:0] symbols_expected;
  logic                      root_dirty;
  logic                      slot_free;
  htw_pkg::htw_emit_t        emit;

  logic                      wr_en;
  logic [ADDR_W-1:0]         wr_addr;
  logic [ENTRY_W-1:0]        wr_data;
  logic                      rd_en;
  logic [ADDR_W-1:0]         rd_addr;
  logic [ENTRY_W-1:0]        rd_data;

  assign root_dirty = cfg_wr_en && (cfg_index == htw_pkg::REG_ROOT_INDEX);

  always_ff @(posedge clk) begin
    if (rst) begin
      root_addr        <= '0;
      symbols_expected <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == htw_pkg::REG_ROOT_INDEX) begin
        root_addr <= ADDR_W'(htw_pkg::wrap_index(cfg_wdata[htw_pkg::IDX_W-1:0],
                                                 NODE_COUNT));
      end else begin
        symbols_expected <= cfg_wdata[htw_pkg::CNT_W-1:0];
      end
    end
  end

  // Output register: advance whenever empty or being taken
  assign slot_free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (slot_free) begin
      result.valid <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && emit.valid) begin
      result.symbol <= emit.symbol;
      result.last   <= emit.last;
    end
  end

  htw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  htw_ctrl #(
    .NODE_COUNT (NODE_COUNT)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .item             (item),
    .root_addr        (root_addr),
    .root_dirty       (root_dirty),
    .symbols_expected (symbols_expected),
    .slot_free        (slot_free),
    .emit             (emit),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data)
  );

endmodule
